// ===== design/bccne_pkg.sv =====
package bccne_pkg;

  localparam int unsigned BOX_W   = 9;
  localparam int unsigned SX_W    = BOX_W + 1;
  localparam int unsigned SXY_W   = SX_W + BOX_W;
  localparam int unsigned ID_W    = 25;
  localparam int unsigned X_W     = 9;
  localparam int unsigned YZ_W    = 8;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned TOTAL_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Largest box sizes the block supports
  localparam logic [BOX_W-1:0] BOX_MAX_X = 9'd256;
  localparam logic [BOX_W-1:0] BOX_MAX_Y = 9'd256;
  localparam logic [BOX_W-1:0] BOX_MAX_Z = 9'd256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;

  // Request kinds
  localparam logic REQ_NN1 = 1'b0;
  localparam logic REQ_NN2 = 1'b1;

  // Keep masks for first neighbors
  localparam logic [7:0] KEEP_ALL  = 8'hFF;
  localparam logic [7:0] KEEP_XLO  = 8'hF0;
  localparam logic [7:0] KEEP_XHI  = 8'h0F;
  localparam logic [7:0] KEEP_YLO  = 8'hCC;
  localparam logic [7:0] KEEP_ZLO  = 8'hAA;
  localparam logic [7:0] KEEP_YHI  = 8'h33;
  localparam logic [7:0] KEEP_ZHI  = 8'h55;

  // Second neighbor direction slots
  localparam logic [SLOT_W-1:0] NN2_XM = 3'd0;
  localparam logic [SLOT_W-1:0] NN2_YM = 3'd1;
  localparam logic [SLOT_W-1:0] NN2_ZM = 3'd2;
  localparam logic [SLOT_W-1:0] NN2_ZP = 3'd3;
  localparam logic [SLOT_W-1:0] NN2_YP = 3'd4;
  localparam logic [SLOT_W-1:0] NN2_XP = 3'd5;

  typedef struct packed {
    logic            req_type;
    logic [X_W-1:0]  site_x;
    logic [YZ_W-1:0] site_y;
    logic [YZ_W-1:0] site_z;
  } bccne_req_t;

  typedef struct packed {
    logic [ID_W-1:0]    neighbor_id;
    logic [X_W-1:0]     neighbor_x;
    logic [YZ_W-1:0]    neighbor_y;
    logic [YZ_W-1:0]    neighbor_z;
    logic [SLOT_W-1:0]  direction_slot;
    logic [TOTAL_W-1:0] neighbor_total;
    logic               last;
    logic               empty_res;
  } bccne_res_t;

endpackage

// ===== design/bcc_lattice_neighbor_enumerator.sv =====
// Channel   Handshake                Payload          Notes
// request   start / busy             req_i            taken when start & !busy
// result    res_valid_o (strobe)     res_o            one cycle each, no back-pressure
// config    cfg_we_i                 cfg_idx_i/data_i written at once, no read-back
//
// A request yields 1 to 8 results, one per cycle, so requests are taken no faster
// than the serializer that walks the keep mask emits their results. From accept,
// a request passes the capture, mask, serializer, select, multiply and sum
// registers in that order before its first result. busy rises only while the
// serializer still walks a request and both front stages hold requests.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets all box sizes to 1.
module bcc_lattice_neighbor_enumerator
  import bccne_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bccne_req_t           req_i,
  output logic                 res_valid_o,
  output bccne_res_t           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BOX_W-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration: box sizes, clamped on write to 1..max
  // ---------------------------------------------------------------------------
  logic [BOX_W-1:0] box_x_q, box_y_q, box_z_q;
  logic [SXY_W-1:0] sxy_q;
  logic [SX_W-1:0]  sx;

  function automatic logic [BOX_W-1:0] sat_box(logic [BOX_W-1:0] v, logic [BOX_W-1:0] maxv);
    logic [BOX_W-1:0] r;
    r = v;
    if (v == '0) r = BOX_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= BOX_W'(1);
      box_y_q <= BOX_W'(1);
      box_z_q <= BOX_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOX_X: box_x_q <= sat_box(cfg_data_i, BOX_MAX_X);
        CFG_BOX_Y: box_y_q <= sat_box(cfg_data_i, BOX_MAX_Y);
        CFG_BOX_Z: box_z_q <= sat_box(cfg_data_i, BOX_MAX_Z);
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Lattice x extent is twice the cell count
  assign sx = {box_x_q, 1'b0};

  // Plane size sx*sy, refreshed every cycle; the user keeps config quiet while requests run (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sxy_q <= SXY_W'(2);
    end else begin
      sxy_q <= SXY_W'(sx) * SXY_W'(box_y_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: each stage moves when the one ahead of it frees up
  // ---------------------------------------------------------------------------
  logic       a_valid_q, b_valid_q, ser_valid_q;
  logic       a_free, b_free, ser_load, ser_done;
  logic       accept;

  bccne_req_t a_req_q, b_req_q, ser_req_q;
  logic [7:0] b_mask_q, ser_mask_q;
  logic [TOTAL_W-1:0] b_total_q, ser_total_q;

  assign ser_load = !ser_valid_q || ser_done;
  assign b_free   = !b_valid_q || ser_load;
  assign a_free   = !a_valid_q || b_free;
  assign busy     = !a_free;
  assign accept   = start && a_free;

  // Stage A: capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_free) begin
      a_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_req_q <= req_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: boundary tests build the keep mask and neighbor count
  // ---------------------------------------------------------------------------
  logic [7:0]         keep;
  logic [TOTAL_W-1:0] keep_cnt;

  always_comb begin
    logic [SX_W-1:0]  x_ext;
    logic [BOX_W-1:0] y_ext, z_ext;
    x_ext = SX_W'(a_req_q.site_x);
    y_ext = BOX_W'(a_req_q.site_y);
    z_ext = BOX_W'(a_req_q.site_z);
    keep  = KEEP_ALL;
    if (a_req_q.req_type == REQ_NN1) begin
      if (x_ext == '0) keep &= KEEP_XLO;
      if (x_ext + SX_W'(1) == sx) keep &= KEEP_XHI;
      if (!a_req_q.site_x[0]) begin
        if (y_ext == '0) keep &= KEEP_YLO;
        if (z_ext == '0) keep &= KEEP_ZLO;
      end else begin
        if (y_ext + BOX_W'(1) == box_y_q) keep &= KEEP_YHI;
        if (z_ext + BOX_W'(1) == box_z_q) keep &= KEEP_ZHI;
      end
    end else begin
      keep = '0;
      keep[NN2_XM] = x_ext >= SX_W'(2);
      keep[NN2_YM] = y_ext != '0;
      keep[NN2_ZM] = z_ext != '0;
      keep[NN2_ZP] = z_ext + BOX_W'(1) != box_z_q;
      keep[NN2_YP] = y_ext + BOX_W'(1) != box_y_q;
      keep[NN2_XP] = x_ext + SX_W'(2) < sx;
    end
    keep_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      keep_cnt = keep_cnt + TOTAL_W'(keep[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_free && a_valid_q) begin
      b_req_q   <= a_req_q;
      b_mask_q  <= keep;
      b_total_q <= keep_cnt;
    end
  end

  // ---------------------------------------------------------------------------
  // Serializer: peel the lowest kept slot each cycle; an empty mask emits once
  // ---------------------------------------------------------------------------
  logic [7:0]        pick, mask_rest;
  logic [SLOT_W-1:0] pick_slot;
  logic              ser_empty;

  assign ser_empty = ser_mask_q == '0;
  assign pick      = ser_mask_q & (~ser_mask_q + 8'd1);
  assign mask_rest = ser_mask_q & ~pick;
  assign ser_done  = mask_rest == '0;

  always_comb begin
    pick_slot = '0;
    for (int i = 0; i < 8; i++) begin
      if (pick[i]) pick_slot = SLOT_W'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
    end else if (ser_load) begin
      ser_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      if (b_valid_q) begin
        ser_req_q   <= b_req_q;
        ser_mask_q  <= b_mask_q;
        ser_total_q <= b_total_q;
      end
    end else begin
      ser_mask_q <= mask_rest;
    end
  end

  // ---------------------------------------------------------------------------
  // E1: hold the chosen slot with its site
  // ---------------------------------------------------------------------------
  logic               e1_valid_q, e1_last_q, e1_empty_q;
  bccne_req_t         e1_req_q;
  logic [SLOT_W-1:0]  e1_slot_q;
  logic [TOTAL_W-1:0] e1_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
    end else begin
      e1_valid_q <= ser_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_valid_q) begin
      e1_req_q   <= ser_req_q;
      e1_slot_q  <= pick_slot;
      e1_total_q <= ser_total_q;
      e1_last_q  <= ser_done;
      e1_empty_q <= ser_empty;
    end
  end

  // ---------------------------------------------------------------------------
  // E2: neighbor coordinates (wrapping to field width) and id products
  // ---------------------------------------------------------------------------
  logic [X_W-1:0]  nx;
  logic [YZ_W-1:0] ny, nz;

  always_comb begin
    nx = e1_req_q.site_x;
    ny = e1_req_q.site_y;
    nz = e1_req_q.site_z;
    if (e1_req_q.req_type == REQ_NN1) begin
      nx = e1_slot_q[2] ? e1_req_q.site_x + X_W'(1) : e1_req_q.site_x - X_W'(1);
      if (!e1_req_q.site_x[0]) begin
        if (!e1_slot_q[1]) ny = e1_req_q.site_y - YZ_W'(1);
        if (!e1_slot_q[0]) nz = e1_req_q.site_z - YZ_W'(1);
      end else begin
        if (e1_slot_q[1]) ny = e1_req_q.site_y + YZ_W'(1);
        if (e1_slot_q[0]) nz = e1_req_q.site_z + YZ_W'(1);
      end
    end else begin
      case (e1_slot_q)
        NN2_XM:  nx = e1_req_q.site_x - X_W'(2);
        NN2_YM:  ny = e1_req_q.site_y - YZ_W'(1);
        NN2_ZM:  nz = e1_req_q.site_z - YZ_W'(1);
        NN2_ZP:  nz = e1_req_q.site_z + YZ_W'(1);
        NN2_YP:  ny = e1_req_q.site_y + YZ_W'(1);
        NN2_XP:  nx = e1_req_q.site_x + X_W'(2);
        default: ;
      endcase
    end
  end

  logic                      e2_valid_q, e2_last_q, e2_empty_q;
  logic [X_W-1:0]            e2_x_q;
  logic [YZ_W-1:0]           e2_y_q, e2_z_q;
  logic [YZ_W+SX_W-1:0]      e2_ysx_q;
  logic [ID_W-1:0]           e2_zsxy_q;
  logic [SLOT_W-1:0]         e2_slot_q;
  logic [TOTAL_W-1:0]        e2_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_valid_q <= 1'b0;
    end else begin
      e2_valid_q <= e1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e1_valid_q) begin
      e2_x_q     <= nx;
      e2_y_q     <= ny;
      e2_z_q     <= nz;
      e2_ysx_q   <= (YZ_W+SX_W)'(ny) * (YZ_W+SX_W)'(sx);
      e2_zsxy_q  <= ID_W'(nz) * ID_W'(sxy_q);
      e2_slot_q  <= e1_slot_q;
      e2_total_q <= e1_total_q;
      e2_last_q  <= e1_last_q;
      e2_empty_q <= e1_empty_q;
    end
  end

  // ---------------------------------------------------------------------------
  // E3: sum the id and drive the result; an empty result is all zero but flags
  // ---------------------------------------------------------------------------
  logic       res_valid_q;
  bccne_res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= e2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e2_valid_q) begin
      if (e2_empty_q) begin
        res_q.neighbor_id    <= '0;
        res_q.neighbor_x     <= '0;
        res_q.neighbor_y     <= '0;
        res_q.neighbor_z     <= '0;
        res_q.direction_slot <= '0;
        res_q.neighbor_total <= '0;
        res_q.last           <= 1'b1;
        res_q.empty_res      <= 1'b1;
      end else begin
        res_q.neighbor_id    <= ID_W'(e2_x_q) + ID_W'(e2_ysx_q) + e2_zsxy_q;
        res_q.neighbor_x     <= e2_x_q;
        res_q.neighbor_y     <= e2_y_q;
        res_q.neighbor_z     <= e2_z_q;
        res_q.direction_slot <= e2_slot_q;
        res_q.neighbor_total <= e2_total_q;
        res_q.last           <= e2_last_q;
        res_q.empty_res      <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== dv/bccne_checker.sv =====
`timescale 1ns / 1ps

module bccne_checker
  import bccne_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  bccne_req_t           req_i,
  input  logic                 res_valid_i,
  input  bccne_res_t           res_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BOX_W-1:0]     cfg_data_i,
  output int unsigned          mismatch_cnt_o,
  output int unsigned          outstanding_o
);

  logic [BOX_W-1:0] box_x, box_y, box_z;
  bccne_res_t       neighbor_q[$];

  function automatic logic [BOX_W-1:0] clamp_box(logic [BOX_W-1:0] v, logic [BOX_W-1:0] lim);
    if (v == '0) return 9'd1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Coordinates wrap to field width; the id is exact, then cut to ID_W bits.
  function automatic bccne_res_t place_neighbor(int nx, int ny, int nz,
                                                logic [SLOT_W-1:0] slot,
                                                longint sx, longint sy);
    bccne_res_t     r;
    longint unsigned id;
    r = '0;
    r.neighbor_x     = nx[X_W-1:0];
    r.neighbor_y     = ny[YZ_W-1:0];
    r.neighbor_z     = nz[YZ_W-1:0];
    id = longint'(r.neighbor_x) + longint'(r.neighbor_y) * sx
       + longint'(r.neighbor_z) * sx * sy;
    r.neighbor_id    = id[ID_W-1:0];
    r.direction_slot = slot;
    return r;
  endfunction

  task automatic enumerate_neighbors(input bccne_req_t r);
    longint     sx, sy, sz;
    int         x, y, z, nx, ny, nz;
    logic [7:0] keep;
    logic       odd;
    bccne_res_t found[$];
    bccne_res_t blank;
    sx = 2 * longint'(box_x);
    sy = longint'(box_y);
    sz = longint'(box_z);
    x  = int'(r.site_x);
    y  = int'(r.site_y);
    z  = int'(r.site_z);
    if (r.req_type == REQ_NN1) begin
      keep = KEEP_ALL;
      odd  = r.site_x[0];
      if (x == 0) keep &= KEEP_XLO;
      if (x + 1 == sx) keep &= KEEP_XHI;
      if (!odd) begin
        if (y == 0) keep &= KEEP_YLO;
        if (z == 0) keep &= KEEP_ZLO;
      end else begin
        if (y + 1 == sy) keep &= KEEP_YHI;
        if (z + 1 == sz) keep &= KEEP_ZHI;
      end
      for (int i = 0; i < 8; i++) begin
        if (keep[i]) begin
          nx = (i < 4) ? x - 1 : x + 1;
          if (!odd) begin
            ny = i[1] ? y : y - 1;
            nz = i[0] ? z : z - 1;
          end else begin
            ny = i[1] ? y + 1 : y;
            nz = i[0] ? z + 1 : z;
          end
          found.push_back(place_neighbor(nx, ny, nz, i[SLOT_W-1:0], sx, sy));
        end
      end
    end else begin
      if (x >= 2)      found.push_back(place_neighbor(x - 2, y, z, NN2_XM, sx, sy));
      if (y != 0)      found.push_back(place_neighbor(x, y - 1, z, NN2_YM, sx, sy));
      if (z != 0)      found.push_back(place_neighbor(x, y, z - 1, NN2_ZM, sx, sy));
      if (z + 1 != sz) found.push_back(place_neighbor(x, y, z + 1, NN2_ZP, sx, sy));
      if (y + 1 != sy) found.push_back(place_neighbor(x, y + 1, z, NN2_YP, sx, sy));
      if (x + 2 < sx)  found.push_back(place_neighbor(x + 2, y, z, NN2_XP, sx, sy));
    end
    if (found.size() == 0) begin
      blank           = '0;
      blank.last      = 1'b1;
      blank.empty_res = 1'b1;
      neighbor_q.push_back(blank);
    end else begin
      foreach (found[k]) begin
        found[k].neighbor_total = TOTAL_W'(found.size());
        found[k].last           = (k == found.size() - 1);
        neighbor_q.push_back(found[k]);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_cnt_o++;
  endtask

  task automatic compare_neighbor(input bccne_res_t got);
    bccne_res_t want;
    if (neighbor_q.size() == 0) begin
      report_mismatch("unrequested result id", 64'(got.neighbor_id), 64'(0));
    end else begin
      want = neighbor_q.pop_front();
      if (got.neighbor_id !== want.neighbor_id)
        report_mismatch("neighbor_id", 64'(got.neighbor_id), 64'(want.neighbor_id));
      if (got.neighbor_x !== want.neighbor_x)
        report_mismatch("neighbor_x", 64'(got.neighbor_x), 64'(want.neighbor_x));
      if (got.neighbor_y !== want.neighbor_y)
        report_mismatch("neighbor_y", 64'(got.neighbor_y), 64'(want.neighbor_y));
      if (got.neighbor_z !== want.neighbor_z)
        report_mismatch("neighbor_z", 64'(got.neighbor_z), 64'(want.neighbor_z));
      if (got.direction_slot !== want.direction_slot)
        report_mismatch("direction_slot", 64'(got.direction_slot),
                        64'(want.direction_slot));
      if (got.neighbor_total !== want.neighbor_total)
        report_mismatch("neighbor_total", 64'(got.neighbor_total),
                        64'(want.neighbor_total));
      if (got.last !== want.last)
        report_mismatch("last", 64'(got.last), 64'(want.last));
      if (got.empty_res !== want.empty_res)
        report_mismatch("empty_res", 64'(got.empty_res), 64'(want.empty_res));
    end
  endtask

  // Sample at the edge: all values seen here are the pre-edge ones.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x          <= 9'd1;
      box_y          <= 9'd1;
      box_z          <= 9'd1;
      neighbor_q.delete();
      mismatch_cnt_o = 0;
      outstanding_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BOX_X: box_x <= clamp_box(cfg_data_i, BOX_MAX_X);
          CFG_BOX_Y: box_y <= clamp_box(cfg_data_i, BOX_MAX_Y);
          CFG_BOX_Z: box_z <= clamp_box(cfg_data_i, BOX_MAX_Z);
          default: ;
        endcase
      end
      if (res_valid_i) compare_neighbor(res_i);
      if (start_i && !busy_i) enumerate_neighbors(req_i);
      outstanding_o <= neighbor_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bccne_pkg::*;

  // Index with no register behind it; the block must drop writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Cycles without any request or result before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 1000;
  // Settle time after the last expected result: accept-to-result latency plus margin.
  localparam int unsigned TAIL_CYCLES = 20;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  bccne_req_t           req_i;
  logic                 res_valid_o;
  bccne_res_t           res_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BOX_W-1:0]     cfg_data_i;

  int unsigned mismatch_cnt;
  int unsigned outstanding;

  // Effective box extents, used only to aim sites at the box walls.
  int unsigned cells_x, cells_y, cells_z;
  int unsigned stall_cycles;

  bcc_lattice_neighbor_enumerator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  bccne_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .res_valid_i   (res_valid_o),
    .res_i         (res_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mismatch_cnt_o(mismatch_cnt),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bccne_req_t site_req(logic kind, int unsigned x, int unsigned y,
                                          int unsigned z);
    bccne_req_t r;
    r.req_type = kind;
    r.site_x   = x[X_W-1:0];
    r.site_y   = y[YZ_W-1:0];
    r.site_z   = z[YZ_W-1:0];
    return r;
  endfunction

  function automatic int unsigned box_extent(logic [BOX_W-1:0] v, logic [BOX_W-1:0] lim);
    if (v == '0) return 1;
    if (v > lim) return 32'(lim);
    return 32'(v);
  endfunction

  // Bias toward the walls of an axis of extent n, where the keep masks bite.
  function automatic int unsigned pick_coord(int unsigned n);
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return n - 1;
      2:       return (n >= 2) ? n - 2 : 0;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  // Mostly sites inside the box; now and then raw bits anywhere in the fields.
  function automatic bccne_req_t random_request();
    bccne_req_t r;
    if ($urandom_range(0, 7) == 0) begin
      r = bccne_req_t'($urandom);
    end else begin
      r.req_type = 1'($urandom_range(0, 1));
      r.site_x   = X_W'(pick_coord(2 * cells_x));
      r.site_y   = YZ_W'(pick_coord(cells_y));
      r.site_z   = YZ_W'(pick_coord(cells_z));
    end
    return r;
  endfunction

  // Hold start and the request until the block takes it. Start stays high on
  // return so that a following request goes out back to back.
  task automatic push_request(input bccne_req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start over a gap of length n; a zero-length gap leaves it untouched.
  task automatic pause(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drop start and wait for every outstanding result; optionally let the
  // pipeline settle so that a register write finds the block idle.
  task automatic drain(input bit settle);
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    if (settle) repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Write all three box registers, then poke the unmapped index with junk.
  task automatic set_box(input logic [BOX_W-1:0] bx, input logic [BOX_W-1:0] by,
                         input logic [BOX_W-1:0] bz);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BOX_X;
    cfg_data_i <= bx;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BOX_Y;
    cfg_data_i <= by;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BOX_Z;
    cfg_data_i <= bz;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPARE;
    cfg_data_i <= BOX_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cells_x = box_extent(bx, BOX_MAX_X);
    cells_y = box_extent(by, BOX_MAX_Y);
    cells_z = box_extent(bz, BOX_MAX_Z);
  endtask

  // Random requests in bursts. With idling on, gaps vary from none to long,
  // and some bursts end with a full drain so the pipeline empties mid-phase.
  task automatic run_random(input int unsigned n_items, input bit with_gaps);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < n_items) begin
          push_request(random_request());
          sent++;
        end
      end
      if (with_gaps) begin
        case ($urandom_range(0, 9))
          0:       drain(1'b0);
          1, 2:    ;
          default: pause($urandom_range(1, 15));
        endcase
      end
    end
  endtask

  // Hang detector: count cycles with neither a request taken nor a result out.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || res_valid_o) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    logic [BOX_W-1:0] bx, by, bz;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_BOX_X;
    cfg_data_i = '0;
    cells_x    = 1;
    cells_y    = 1;
    cells_z    = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset box (2 x 1 x 1): the origin keeps only its upper corner, and the
    // second-neighbor requests find nothing at all, so they come back empty.
    push_request(site_req(REQ_NN1, 0, 0, 0));
    push_request(site_req(REQ_NN2, 0, 0, 0));
    push_request(site_req(REQ_NN1, 1, 0, 0));
    push_request(site_req(REQ_NN2, 1, 0, 0));
    drain(1'b1);

    // Small box 8 x 3 x 5: interior sites of both parities, both far corners,
    // and a site far outside the box whose neighbors wrap around the fields.
    set_box(9'd4, 9'd3, 9'd5);
    push_request(site_req(REQ_NN1, 4, 1, 2));
    push_request(site_req(REQ_NN2, 4, 1, 2));
    push_request(site_req(REQ_NN1, 3, 1, 2));
    push_request(site_req(REQ_NN1, 7, 2, 4));
    push_request(site_req(REQ_NN2, 7, 2, 4));
    push_request(site_req(REQ_NN2, 0, 0, 0));
    push_request(site_req(REQ_NN1, 511, 255, 255));
    push_request(site_req(REQ_NN2, 511, 255, 255));
    push_request(site_req(REQ_NN1, 510, 0, 255));
    drain(1'b1);

    // Out-of-range register values: zero reads as one, overflow saturates.
    set_box(9'd0, 9'd511, 9'd256);
    push_request(site_req(REQ_NN1, 1, 255, 255));
    push_request(site_req(REQ_NN2, 0, 128, 0));
    push_request(site_req(REQ_NN1, 0, 0, 0));
    drain(1'b1);

    // Largest box: the top corner reaches the full id width.
    set_box(9'd256, 9'd256, 9'd256);
    push_request(site_req(REQ_NN1, 511, 255, 255));
    push_request(site_req(REQ_NN2, 511, 255, 255));
    push_request(site_req(REQ_NN1, 0, 0, 0));
    push_request(site_req(REQ_NN2, 0, 0, 0));
    push_request(site_req(REQ_NN1, 256, 128, 128));
    push_request(site_req(REQ_NN2, 255, 128, 128));
    drain(1'b1);

    // Random phases, one box setting each; phase 2 runs without any idling.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          bx = 9'd2; by = 9'd2; bz = 9'd2;
        end
        4: begin
          bx = BOX_W'($urandom); by = BOX_W'($urandom); bz = BOX_W'($urandom);
        end
        5: begin
          bx = BOX_MAX_X; by = BOX_MAX_Y; bz = BOX_MAX_Z;
        end
        default: begin
          bx = BOX_W'($urandom_range(1, 8));
          by = BOX_W'($urandom_range(1, 8));
          bz = BOX_W'($urandom_range(1, 8));
        end
      endcase
      set_box(bx, by, bz);
      run_random(60, p != 2);
      drain(1'b1);
    end

    if (mismatch_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bccne_pkg.sv
design/bcc_lattice_neighbor_enumerator.sv
dv/bccne_checker.sv
dv/tb.sv
